// ===== hw/rtl/tcma_pkg.sv =====
package tcma_pkg;

  localparam int DATA_W    = 32;
  localparam int WIN_REG_W = 7;
  localparam int PLACES_W  = 4;
  localparam int POW10_W   = 14;

  localparam logic [WIN_REG_W-1:0] WINDOW_RESET = 7'd10;
  localparam logic [PLACES_W-1:0]  PLACES_RESET = 4'hF;
  localparam logic [2:0]           MAX_PLACES   = 3'd4;

  // Magnitude limits of a signed 32-bit result
  localparam logic [DATA_W:0]      POS_LIMIT = 33'h0_7FFF_FFFF;
  localparam logic [DATA_W:0]      NEG_LIMIT = 33'h0_8000_0000;
  localparam logic [DATA_W-1:0]    SAT_MAX   = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0]    SAT_MIN   = 32'h8000_0000;

  typedef struct packed {
    logic signed [DATA_W-1:0] forward_speed;
    logic signed [DATA_W-1:0] sideways_speed;
    logic signed [DATA_W-1:0] turn_rate;
  } sample_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] avg_forward;
    logic signed [DATA_W-1:0] avg_sideways;
    logic signed [DATA_W-1:0] avg_turn;
  } result_t;

  typedef struct packed {
    logic [7:0]        index;
    logic [DATA_W-1:0] wdata;
  } cfg_t;

  typedef enum logic [7:0] {
    REG_WINDOW   = 8'd0,
    REG_FORWARD  = 8'd1,
    REG_SIDEWAYS = 8'd2,
    REG_TURN     = 8'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    CH_FORWARD,
    CH_SIDEWAYS,
    CH_TURN
  } chan_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_LOAD,
    ST_SCALE,
    ST_DIV,
    ST_ROUND,
    ST_DONE
  } state_e;

  function automatic logic [POW10_W-1:0] pow10(input logic [2:0] p);
    logic [POW10_W-1:0] r;
    unique case (p)
      3'd0:    r = 14'd1;
      3'd1:    r = 14'd10;
      3'd2:    r = 14'd100;
      3'd3:    r = 14'd1000;
      default: r = 14'd10000;
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/tcma_chan_if.sv =====
interface tcma_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/three_channel_moving_average_round_core.sv =====
// Three-channel moving average with optional decimal rounding.
//
// sample_i carries one odometry transaction (forward speed, sideways speed,
// turn rate, signed Q15.16). result_o returns one transaction per sample with
// the three channel averages, each rounded half away from zero to the places
// set for that channel, or left unrounded when the places register is negative.
// cfg_i writes a register by index: 0 window length, 1..3 places per channel.
// Writing the window length empties the history; other indexes are dropped.
//
// Per sample the core updates the sums, then handles each channel in turn:
// one divider run when unrounded, or scaling by ten per place and two divider
// runs when rounded to p places. The shared restoring divider retires two
// quotient bits per pass and sets the rate. sample_i is ready only between
// samples.
// A finished result sits in the output register; a stalled receiver holds it
// there while the next sample is taken, and the core waits before loading the
// next result only if the previous one is still not taken.
// Reset restores window 10, no rounding and an empty history.
module three_channel_moving_average_round_core #(
  parameter int MAX_WINDOW = 64,
  parameter int FRAC_BITS  = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  tcma_chan_if.sink   sample_i,
  tcma_chan_if.source result_o,
  tcma_chan_if.sink   cfg_i
);

  import tcma_pkg::*;

  localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
  localparam int SLOT_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int SUM_W  = DATA_W + $clog2(MAX_WINDOW);
  localparam int NUM_W  = SUM_W + POW10_W;
  localparam int DIV_W  = NUM_W + (NUM_W % 2);
  localparam int ITER   = DIV_W / 2;
  localparam int ITER_W = $clog2(ITER);
  localparam int DEN_W  = (CNT_W + FRAC_BITS > POW10_W) ? CNT_W + FRAC_BITS : POW10_W;

  // Configuration registers
  logic [WIN_REG_W-1:0] window_q;
  logic [PLACES_W-1:0]  fwd_places_q, side_places_q, turn_places_q;

  // Window state
  state_e                   state_q, state_d;
  chan_e                    ch_q;
  sample_t                  sample_q;
  logic [SLOT_W-1:0]        slot_q;
  logic [CNT_W-1:0]         held_q;
  logic signed [SUM_W-1:0]  sum_q [3];

  // History ring, all three channels side by side
  logic [3*DATA_W-1:0]      hist_mem [MAX_WINDOW];
  logic [3*DATA_W-1:0]      hist_rd_q;

  // Shared divider and scaler
  logic signed [NUM_W-1:0]  x_q;
  logic [2:0]               pcnt_q, p_q;
  logic                     final_q;
  logic [DIV_W-1:0]         num_q;
  logic [DEN_W-1:0]         rem_q, den_q;
  logic                     neg_q;
  logic [ITER_W-1:0]        step_q;

  logic [DATA_W-1:0]        res_q [3];
  logic                     out_valid_q;

  // Combinational helpers
  logic [CNT_W-1:0]         win_eff;
  logic                     full;
  logic [CNT_W-1:0]         slot_inc;
  logic [PLACES_W-1:0]      places_sel;
  logic signed [SUM_W-1:0]  sum_sel;
  logic [2:0]               p_clamp;
  chan_e                    ch_next;

  logic                     div_start, start_final;
  logic signed [NUM_W-1:0]  start_num;
  logic [NUM_W-1:0]         start_abs;
  logic [DEN_W-1:0]         start_den;

  logic [DIV_W-1:0]         dn;
  logic [DEN_W-1:0]         dr;
  logic [DEN_W:0]           trial;
  logic                     qbit;

  logic                     round_up;
  logic [DIV_W:0]           mag;
  logic signed [DIV_W+1:0]  res_s;
  logic [DATA_W-1:0]        sat;
  logic                     out_load;

  logic signed [DATA_W-1:0] old_f, old_s, old_t;

  assign win_eff = (window_q == '0) ? CNT_W'(1) :
                   (int'(window_q) > MAX_WINDOW) ? CNT_W'(MAX_WINDOW) : CNT_W'(window_q);
  assign full     = (held_q >= win_eff);
  assign slot_inc = CNT_W'(slot_q) + CNT_W'(1);

  assign old_f = hist_rd_q[3*DATA_W-1:2*DATA_W];
  assign old_s = hist_rd_q[2*DATA_W-1:DATA_W];
  assign old_t = hist_rd_q[DATA_W-1:0];

  assign sample_i.ready = (state_q == ST_IDLE);
  assign cfg_i.ready    = 1'b1;
  assign result_o.valid = out_valid_q;

  always_comb begin
    unique case (ch_q)
      CH_FORWARD: begin
        places_sel = fwd_places_q;
        sum_sel    = sum_q[0];
        ch_next    = CH_SIDEWAYS;
      end
      CH_SIDEWAYS: begin
        places_sel = side_places_q;
        sum_sel    = sum_q[1];
        ch_next    = CH_TURN;
      end
      default: begin
        places_sel = turn_places_q;
        sum_sel    = sum_q[2];
        ch_next    = CH_FORWARD;
      end
    endcase
  end

  assign p_clamp = (places_sel[2:0] > MAX_PLACES) ? MAX_PLACES : places_sel[2:0];

  // Divider: two restoring steps per cycle
  always_comb begin
    dn = num_q;
    dr = rem_q;
    trial = '0;
    qbit = 1'b0;
    for (int i = 0; i < 2; i++) begin
      trial = {dr, dn[DIV_W-1]};
      qbit  = (trial >= {1'b0, den_q});
      if (qbit) begin
        trial = trial - {1'b0, den_q};
      end
      dr = trial[DEN_W-1:0];
      dn = {dn[DIV_W-2:0], qbit};
    end
  end

  // Round half away from zero, restore sign, saturate to 32 bits
  assign round_up = ({rem_q, 1'b0} >= {1'b0, den_q});
  assign mag      = {1'b0, num_q} + (DIV_W+1)'(round_up);
  assign res_s    = neg_q ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  assign sat      = (!neg_q && (mag > (DIV_W+1)'(POS_LIMIT))) ? SAT_MAX :
                    (neg_q && (mag > (DIV_W+1)'(NEG_LIMIT))) ? SAT_MIN : res_s[DATA_W-1:0];

  assign out_load = (state_q == ST_DONE) && (!out_valid_q || result_o.ready);

  // Sequencer
  always_comb begin
    state_d     = state_q;
    div_start   = 1'b0;
    start_final = 1'b0;
    start_num   = '0;
    start_den   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (sample_i.valid) state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        if (places_sel[PLACES_W-1]) begin
          // Unrounded: divide the sum by the count
          div_start   = 1'b1;
          start_final = 1'b1;
          start_num   = NUM_W'(sum_sel);
          start_den   = DEN_W'(held_q);
          state_d     = ST_DIV;
        end else begin
          state_d = ST_SCALE;
        end
      end
      ST_SCALE: begin
        if (pcnt_q == '0) begin
          // Scaled sum over count * 2^FRAC_BITS gives decimal units
          div_start = 1'b1;
          start_num = x_q;
          start_den = DEN_W'(held_q) << FRAC_BITS;
          state_d   = ST_DIV;
        end
      end
      ST_DIV: begin
        if (step_q == ITER_W'(ITER - 1)) state_d = ST_ROUND;
      end
      ST_ROUND: begin
        if (!final_q) begin
          // Back from decimal units to the binary fraction
          div_start   = 1'b1;
          start_final = 1'b1;
          start_num   = NUM_W'(res_s) <<< FRAC_BITS;
          start_den   = DEN_W'(pow10(p_q));
          state_d     = ST_DIV;
        end else if (ch_q == CH_TURN) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_LOAD;
        end
      end
      ST_DONE: begin
        if (out_load) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign start_abs = start_num[NUM_W-1] ? NUM_W'(-start_num) : NUM_W'(start_num);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Control state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q      <= WINDOW_RESET;
      fwd_places_q  <= PLACES_RESET;
      side_places_q <= PLACES_RESET;
      turn_places_q <= PLACES_RESET;
      held_q        <= '0;
      slot_q        <= '0;
      ch_q          <= CH_FORWARD;
      out_valid_q   <= 1'b0;
      for (int c = 0; c < 3; c++) begin
        sum_q[c] <= '0;
      end
    end else begin
      if (cfg_i.valid) begin
        unique case (cfg_i.data.index)
          REG_WINDOW: begin
            window_q <= cfg_i.data.wdata[WIN_REG_W-1:0];
            held_q   <= '0;
            slot_q   <= '0;
            for (int c = 0; c < 3; c++) begin
              sum_q[c] <= '0;
            end
          end
          REG_FORWARD:  fwd_places_q  <= cfg_i.data.wdata[PLACES_W-1:0];
          REG_SIDEWAYS: side_places_q <= cfg_i.data.wdata[PLACES_W-1:0];
          REG_TURN:     turn_places_q <= cfg_i.data.wdata[PLACES_W-1:0];
          default: ;
        endcase
      end else if (state_q == ST_UPDATE) begin
        // Drop the oldest sample once the window is full, add the new one
        sum_q[0] <= sum_q[0] - (full ? SUM_W'(old_f) : '0) + SUM_W'(sample_q.forward_speed);
        sum_q[1] <= sum_q[1] - (full ? SUM_W'(old_s) : '0) + SUM_W'(sample_q.sideways_speed);
        sum_q[2] <= sum_q[2] - (full ? SUM_W'(old_t) : '0) + SUM_W'(sample_q.turn_rate);
        held_q   <= full ? win_eff : held_q + CNT_W'(1);
        slot_q   <= (slot_inc == win_eff) ? '0 : SLOT_W'(slot_inc);
      end

      if (state_q == ST_UPDATE) begin
        ch_q <= CH_FORWARD;
      end else if (state_q == ST_ROUND && final_q) begin
        ch_q <= ch_next;
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // History ring: read every cycle at the write slot, write on update
  always_ff @(posedge clk_i) begin
    if (state_q == ST_UPDATE) begin
      hist_mem[slot_q] <= sample_q;
    end
    hist_rd_q <= hist_mem[slot_q];
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (sample_i.valid && sample_i.ready) begin
      sample_q <= sample_i.data;
    end

    if (state_q == ST_LOAD) begin
      x_q    <= NUM_W'(sum_sel);
      pcnt_q <= p_clamp;
      p_q    <= p_clamp;
    end else if (state_q == ST_SCALE && pcnt_q != '0) begin
      // Times ten as eight plus two
      x_q    <= (x_q <<< 3) + (x_q <<< 1);
      pcnt_q <= pcnt_q - 3'd1;
    end

    if (div_start) begin
      num_q   <= DIV_W'(start_abs);
      neg_q   <= start_num[NUM_W-1];
      rem_q   <= '0;
      den_q   <= start_den;
      step_q  <= '0;
      final_q <= start_final;
    end else if (state_q == ST_DIV) begin
      num_q  <= dn;
      rem_q  <= dr;
      step_q <= step_q + ITER_W'(1);
    end

    if (state_q == ST_ROUND && final_q) begin
      res_q[ch_q] <= sat;
    end

    if (out_load) begin
      result_o.data.avg_forward  <= res_q[0];
      result_o.data.avg_sideways <= res_q[1];
      result_o.data.avg_turn     <= res_q[2];
    end
  end

  // The fill count never passes the window in force
  a_held_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= win_eff)
    else $error("held count exceeds window");

  // The write slot stays inside the window
  a_slot_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CNT_W'(slot_q) < win_eff)
    else $error("write slot outside window");

  // Leaving the done state always presents a result
  a_done_shows_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && state_d == ST_IDLE) |=> result_o.valid)
    else $error("result not presented after completion");

  // A result is loaded only into a free or draining output register
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || result_o.ready))
    else $error("pending result overwritten");

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tcma_pkg::*;

  localparam int MAX_WINDOW = 64;
  localparam int FRAC_BITS  = 16;

  // Watchdog limit on cycles without any transaction, and the quiet tail
  // after the last result (longer than the slowest sample).
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 300;

  localparam int RANDOM_PHASES   = 16;
  localparam int ITEMS_PER_PHASE = 100;

  // Register codes beyond the last real one must be ignored by the core.
  localparam int FIRST_UNUSED_REG = int'(REG_TURN) + 1;
  localparam int TOP_REG_CODE     = 255;
  localparam int TOP_WINDOW_CODE  = (1 << WIN_REG_W) - 1;

  localparam longint S32_HI = longint'($signed(SAT_MAX));
  localparam longint S32_LO = longint'($signed(SAT_MIN));

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  tcma_chan_if #(.payload_t(sample_t)) sample_if ();
  tcma_chan_if #(.payload_t(result_t)) result_if ();
  tcma_chan_if #(.payload_t(cfg_t))    cfg_if ();

  three_channel_moving_average_round_core #(
    .MAX_WINDOW (MAX_WINDOW),
    .FRAC_BITS  (FRAC_BITS)
  ) DUT (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .sample_i (sample_if),
    .result_o (result_if),
    .cfg_i    (cfg_if)
  );

  always begin
    #6ns clk = 1'b1;
    #6ns clk = 0;
  end

  // ---------------------------------------------------------------------------
  // Averaging model: register copies and per-channel history, kept in step
  // with every accepted configuration write and sample transaction.
  // ---------------------------------------------------------------------------
  logic [WIN_REG_W-1:0] window_q = WINDOW_RESET;
  logic [PLACES_W-1:0]  places_q [3] = '{default: PLACES_RESET};
  longint               chan_hist [3][MAX_WINDOW] = '{default: '{default: 0}};
  longint               chan_sum [3] = '{default: 0};
  int unsigned          held = 0;
  int unsigned          next_slot = 0;

  cfg_reg_e places_reg [3] = '{REG_FORWARD, REG_SIDEWAYS, REG_TURN};

  // Quotient rounded half away from zero; the divisor is always positive.
  function automatic longint round_div(longint num, longint den);
    longint unsigned mag, dd, q;
    mag = (num < 0) ? longint'(-num) : num;
    dd  = den;
    q   = (2 * mag + dd) / (2 * dd);
    return (num < 0) ? -longint'(q) : longint'(q);
  endfunction

  // Average one channel, round it to the decimal places code (negative
  // codes leave it unrounded, codes above four act as four) and saturate.
  function automatic logic [DATA_W-1:0] round_channel(longint acc, int unsigned n,
                                                      logic [PLACES_W-1:0] code);
    logic signed [PLACES_W-1:0] pl;
    longint scale, k, r;
    pl    = code;
    scale = 1;
    if (pl < 0) begin
      r = round_div(acc, longint'(n));
    end else begin
      repeat ((pl > int'(MAX_PLACES)) ? int'(MAX_PLACES) : int'(pl)) scale = scale * 10;
      k = round_div(acc * scale, longint'(n) << FRAC_BITS);
      r = round_div(k * (longint'(1) << FRAC_BITS), scale);
    end
    if (r > S32_HI) r = S32_HI;
    if (r < S32_LO) r = S32_LO;
    return r[DATA_W-1:0];
  endfunction

  // Push one sample into the rings and work out the three averages.
  function automatic result_t predict_average(sample_t s);
    int unsigned w, slot;
    int          c;
    longint      fresh [3];
    logic [DATA_W-1:0] avg [3];
    if (window_q == 0) w = 1;
    else if (window_q > MAX_WINDOW) w = MAX_WINDOW;
    else w = window_q;
    slot = next_slot % w;
    fresh[CH_FORWARD]  = longint'($signed(s.forward_speed));
    fresh[CH_SIDEWAYS] = longint'($signed(s.sideways_speed));
    fresh[CH_TURN]     = longint'($signed(s.turn_rate));
    if (held >= w) begin
      for (c = 0; c < 3; c++) chan_sum[c] -= chan_hist[c][slot];
      held = w;
    end else begin
      held++;
    end
    for (c = 0; c < 3; c++) begin
      chan_hist[c][slot] = fresh[c];
      chan_sum[c] += fresh[c];
      avg[c] = round_channel(chan_sum[c], held, places_q[c]);
    end
    next_slot = (slot + 1) % w;
    return '{avg_forward: avg[CH_FORWARD], avg_sideways: avg[CH_SIDEWAYS],
             avg_turn: avg[CH_TURN]};
  endfunction

  // ---------------------------------------------------------------------------
  // Sample driver: advance through the pending queue, hold the transaction
  // until it is taken, and insert random idle bursts.
  // ---------------------------------------------------------------------------
  sample_t     pending_samples [$];
  result_t     expected_avgs [$];
  int unsigned samples_queued = 0;
  int unsigned samples_taken  = 0;
  int          idle_pct = 0;
  int          gap_left = 0;
  int          stall_left = 0;
  int unsigned mismatches = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      sample_if.valid <= 1'b0;
      sample_if.data  <= '0;
    end else begin
      // Record the expectation at the edge that moves the transaction.
      if (sample_if.valid && sample_if.ready) begin
        expected_avgs.insert(expected_avgs.size(), predict_average(sample_if.data));
        samples_taken++;
      end
      if (!sample_if.valid || sample_if.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          sample_if.valid <= 1'b0;
        end else if (pending_samples.size() != 0 && idle_pct != 0 &&
                     $urandom_range(0, 99) < idle_pct) begin
          gap_left = $urandom_range(0, 2);
          sample_if.valid <= 1'b0;
        end else if (pending_samples.size() != 0) begin
          sample_if.valid <= 1'b1;
          sample_if.data  <= pending_samples[0];
          pending_samples.delete(0);
        end else begin
          sample_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result back-pressure: drop ready in random bursts.
  always @(posedge clk) begin
    if (!rst_n) begin
      stall_left = 0;
      result_if.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      result_if.ready <= 1'b0;
    end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      stall_left = $urandom_range(0, 2);
      result_if.ready <= 1'b0;
    end else begin
      result_if.ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: compare each transaction with the oldest expectation.
  // ---------------------------------------------------------------------------
  result_t oldest_avg;

  task automatic check_field(string field, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
    if (want !== got) begin
      mismatches++;
      $error("%s: expected %0d, actual %0d", field, $signed(want), $signed(got));
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && result_if.valid && result_if.ready) begin
      if (expected_avgs.size() == 0) begin
        mismatches++;
        $error("result transaction with none expected");
      end else begin
        oldest_avg = expected_avgs[0];
        expected_avgs.delete(0);
        check_field("avg_forward", oldest_avg.avg_forward, result_if.data.avg_forward);
        check_field("avg_sideways", oldest_avg.avg_sideways, result_if.data.avg_sideways);
        check_field("avg_turn", oldest_avg.avg_turn, result_if.data.avg_turn);
      end
    end
  end

  // Watchdog: end the run if no channel moves a transaction for too long.
  int unsigned quiet_cycles = 0;

  always @(posedge clk) begin
    if ((sample_if.valid && sample_if.ready) || (result_if.valid && result_if.ready) ||
        (cfg_if.valid && cfg_if.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  int drift_base [3];
  int drift_span [3];

  function automatic sample_t odometry(logic [DATA_W-1:0] f, logic [DATA_W-1:0] s,
                                       logic [DATA_W-1:0] t);
    return '{forward_speed: f, sideways_speed: s, turn_rate: t};
  endfunction

  task automatic queue_sample(sample_t s);
    pending_samples.insert(pending_samples.size(), s);
    samples_queued++;
  endtask

  // Fill the unused upper bits of a register write with noise.
  function automatic logic [DATA_W-1:0] noisy(logic [DATA_W-1:0] v, int w);
    logic [DATA_W-1:0] mask;
    mask = (32'd1 << w) - 1;
    return ($urandom() & ~mask) | (v & mask);
  endfunction

  // Hold valid high across back-to-back writes; the model takes the value
  // at the edge that moves the transaction.
  task automatic write_register(logic [7:0] idx, logic [DATA_W-1:0] value);
    cfg_t req;
    req = '{index: idx, wdata: value};
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= req;
    do @(posedge clk); while (!cfg_if.ready);
    case (req.index)
      REG_WINDOW: begin
        window_q  = req.wdata[WIN_REG_W-1:0];
        chan_hist = '{default: '{default: 0}};
        chan_sum  = '{default: 0};
        held      = 0;
        next_slot = 0;
      end
      REG_FORWARD:  places_q[CH_FORWARD]  = req.wdata[PLACES_W-1:0];
      REG_SIDEWAYS: places_q[CH_SIDEWAYS] = req.wdata[PLACES_W-1:0];
      REG_TURN:     places_q[CH_TURN]     = req.wdata[PLACES_W-1:0];
      default: ;
    endcase
  endtask

  task automatic release_register_port();
    cfg_if.valid <= 1'b0;
  endtask

  // Wait until every queued sample is taken and every result has arrived.
  task automatic wait_drained();
    while (samples_taken != samples_queued || expected_avgs.size() != 0) @(posedge clk);
  endtask

  function automatic int pick_window();
    int w;
    case ($urandom_range(0, 9))
      0:       w = 0;
      1:       w = 1;
      2:       w = MAX_WINDOW;
      3:       w = $urandom_range(MAX_WINDOW + 1, TOP_WINDOW_CODE);
      4:       w = 2;
      default: w = $urandom_range(1, MAX_WINDOW);
    endcase
    return w;
  endfunction

  // Mostly the meaningful range -1..4, sometimes any 4-bit code.
  function automatic int pick_places();
    int r;
    r = $urandom_range(0, 15);
    return (r < 6) ? r - 1 : int'($urandom_range(0, 15));
  endfunction

  // Mix full-range noise, extremes, small speeds and a slow drift around a
  // base, which keeps averages close to rounding boundaries.
  function automatic logic [DATA_W-1:0] pick_value(int c);
    int v;
    case ($urandom_range(0, 9))
      0: v = $urandom();
      1: begin
        case ($urandom_range(0, 3))
          0:       v = SAT_MAX;
          1:       v = SAT_MIN;
          2:       v = 0;
          default: v = -1;
        endcase
      end
      2, 3:    v = int'($urandom_range(0, 32'h1F_FFFF)) - 32'h10_0000;
      default: v = drift_base[c] + int'($urandom_range(0, 2 * drift_span[c])) - drift_span[c];
    endcase
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int phase, c;
    cfg_if.valid    <= 1'b0;
    cfg_if.data     <= '0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: window of ten, no rounding, field extremes.
    queue_sample(odometry('0, '0, '0));
    queue_sample(odometry(SAT_MAX, SAT_MAX, SAT_MAX));
    queue_sample(odometry(SAT_MIN, SAT_MIN, SAT_MIN));
    queue_sample(odometry('1, 32'd1, SAT_MAX));
    queue_sample(odometry(32'd1, '1, SAT_MIN));
    wait_drained();

    // Window of one, rounding to 0, 1 and 4 places: full-scale inputs must
    // saturate, halves must round away from zero. Unknown codes are ignored.
    write_register(REG_WINDOW, noisy(1, WIN_REG_W));
    write_register(REG_FORWARD, noisy(0, PLACES_W));
    write_register(REG_SIDEWAYS, noisy(1, PLACES_W));
    write_register(REG_TURN, noisy(4, PLACES_W));
    write_register(8'(FIRST_UNUSED_REG), $urandom());
    write_register(8'(TOP_REG_CODE), $urandom());
    release_register_port();
    queue_sample(odometry(SAT_MAX, SAT_MAX, SAT_MAX));
    queue_sample(odometry(SAT_MIN, SAT_MIN, SAT_MIN));
    queue_sample(odometry(32'sd32768, 32'sd32768, 32'sd32768));
    queue_sample(odometry(-32'sd32768, -32'sd3277, -32'sd4));
    queue_sample(odometry(32'sd98304, 32'sd9830, 32'sd3));
    queue_sample(odometry(SAT_MAX - 1, SAT_MIN + 1, '1));
    wait_drained();

    // Window code zero acts as one; places codes above four act as four.
    write_register(REG_WINDOW, noisy(0, WIN_REG_W));
    write_register(REG_FORWARD, noisy(5, PLACES_W));
    write_register(REG_SIDEWAYS, noisy(6, PLACES_W));
    write_register(REG_TURN, noisy(7, PLACES_W));
    release_register_port();
    queue_sample(odometry(SAT_MAX, 32'sd12345, -32'sd12345));
    queue_sample(odometry(SAT_MIN, 32'sd3, -32'sd3));
    queue_sample(odometry(32'sd65536, -32'sd65536, 32'sd7));
    wait_drained();

    // Window code above the ring size acts as the ring size; any negative
    // places code disables rounding.
    write_register(REG_WINDOW, noisy(TOP_WINDOW_CODE, WIN_REG_W));
    write_register(REG_FORWARD, noisy(-8, PLACES_W));
    write_register(REG_SIDEWAYS, noisy(-1, PLACES_W));
    write_register(REG_TURN, noisy(3, PLACES_W));
    release_register_port();
    queue_sample(odometry(SAT_MAX, SAT_MIN, 32'sd100000));
    queue_sample(odometry(SAT_MAX, SAT_MIN, -32'sd7));
    queue_sample(odometry(32'sd5, 32'sd5, SAT_MAX));
    wait_drained();

    // Window of two: exact halves in the unrounded average.
    write_register(REG_WINDOW, noisy(2, WIN_REG_W));
    write_register(REG_FORWARD, noisy(-1, PLACES_W));
    write_register(REG_TURN, noisy(2, PLACES_W));
    release_register_port();
    queue_sample(odometry(32'sd1, -32'sd1, 32'sd655));
    queue_sample(odometry(32'sd2, -32'sd2, 32'sd656));
    queue_sample(odometry(-32'sd1, 32'sd1, -32'sd655));
    queue_sample(odometry(-32'sd2, 32'sd2, -32'sd656));
    wait_drained();

    // Random phases: fresh settings between phases, idling varied per
    // phase and switched off for the final one.
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase == 0 || $urandom_range(0, 9) < 7)
        write_register(REG_WINDOW, noisy(pick_window(), WIN_REG_W));
      for (c = 0; c < 3; c++)
        if ($urandom_range(0, 3) != 0)
          write_register(places_reg[c], noisy(pick_places(), PLACES_W));
      if ($urandom_range(0, 3) == 0)
        write_register(8'($urandom_range(FIRST_UNUSED_REG, TOP_REG_CODE)), $urandom());
      release_register_port();

      case ($urandom_range(0, 2))
        0:       idle_pct = 0;
        1:       idle_pct = 10;
        default: idle_pct = 35;
      endcase
      if (phase == RANDOM_PHASES - 1) idle_pct = 0;

      for (c = 0; c < 3; c++) begin
        drift_base[c] = int'($urandom()) >>> $urandom_range(0, 12);
        drift_span[c] = 1 << $urandom_range(0, 16);
      end
      repeat (ITEMS_PER_PHASE)
        queue_sample(odometry(pick_value(CH_FORWARD), pick_value(CH_SIDEWAYS),
                              pick_value(CH_TURN)));
      wait_drained();
    end

    // Let any stray result surface before the verdict.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_avgs.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
